>>> hdl/mrwt_pkg.sv
// ----------------------------------------------------------------------------
// Miller-Rabin witness test package
// Word width, sequencer step addresses, control word layout and the
// microcode program that runs one round of the test.
// ----------------------------------------------------------------------------
`default_nettype none

package mrwt_pkg;

	// Arithmetic word width
	localparam int WIDTH  = 32;
	localparam int CNT_W  = $clog2(WIDTH + 1);
	localparam int R_W    = $clog2(WIDTH);

	// Sequencer
	localparam int STEP_W = 4;
	localparam int OP_W   = 4;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [WIDTH-1:0]  word_t;

	// Micro-operations
	localparam op_t OP_WAIT  = 4'd0;   // wait for an item and load it
	localparam op_t OP_JLT2  = 4'd1;   // jump if candidate below two
	localparam op_t OP_MUL   = 4'd2;   // modular multiply, stay until done
	localparam op_t OP_NORM  = 4'd3;   // strip one trailing zero of d per cycle
	localparam op_t OP_JDZ   = 4'd4;   // jump if exponent exhausted
	localparam op_t OP_JBIT0 = 4'd5;   // jump if exponent bit clear
	localparam op_t OP_SHD   = 4'd6;   // shift exponent, jump
	localparam op_t OP_TEST  = 4'd7;   // jump if x is one or n-1
	localparam op_t OP_RDEC  = 4'd8;   // jump if no squarings left, else count one
	localparam op_t OP_CHK   = 4'd9;   // classify x after a squaring
	localparam op_t OP_EMIT  = 4'd10;  // present the verdict
	localparam op_t OP_JMP   = 4'd11;  // unconditional jump

	// Multiplier operand selects
	localparam logic [1:0] XS_ONE = 2'd0;
	localparam logic [1:0] XS_X   = 2'd1;
	localparam logic [1:0] XS_B   = 2'd2;
	localparam logic [1:0] YS_W   = 2'd0;
	localparam logic [1:0] YS_B   = 2'd1;
	localparam logic [1:0] YS_X   = 2'd2;
	localparam logic       MS_N   = 1'b0;
	localparam logic       MS_NM1 = 1'b1;
	localparam logic       DS_X   = 1'b0;
	localparam logic       DS_B   = 1'b1;

	// Step addresses
	localparam step_t S_IDLE = 4'd0;
	localparam step_t S_CHKN = 4'd1;
	localparam step_t S_RED  = 4'd2;
	localparam step_t S_NORM = 4'd3;
	localparam step_t S_ETOP = 4'd4;
	localparam step_t S_EBIT = 4'd5;
	localparam step_t S_MULX = 4'd6;
	localparam step_t S_SQB  = 4'd7;
	localparam step_t S_SHD  = 4'd8;
	localparam step_t S_TEST = 4'd9;
	localparam step_t S_RDEC = 4'd10;
	localparam step_t S_SQX  = 4'd11;
	localparam step_t S_CHK  = 4'd12;
	localparam step_t S_PASS = 4'd13;
	localparam step_t S_FAIL = 4'd14;

	typedef struct packed {
		op_t        op;
		step_t      target;
		logic [1:0] xsel;
		logic [1:0] ysel;
		logic       msel;
		logic       dst;
		logic       verdict;
	} ctrl_t;

	// Microcode program
	function automatic ctrl_t ctrl_rom(input step_t s);
		ctrl_t c;
		c = '0;
		unique case (s)
			S_IDLE: c.op = OP_WAIT;
			S_CHKN: begin
				c.op     = OP_JLT2;
				c.target = S_FAIL;
			end
			// b = witness mod (n-1), by multiplying it with one
			S_RED: begin
				c.op   = OP_MUL;
				c.xsel = XS_ONE;
				c.ysel = YS_W;
				c.msel = MS_NM1;
				c.dst  = DS_B;
			end
			S_NORM: c.op = OP_NORM;
			S_ETOP: begin
				c.op     = OP_JDZ;
				c.target = S_TEST;
			end
			S_EBIT: begin
				c.op     = OP_JBIT0;
				c.target = S_SQB;
			end
			S_MULX: begin
				c.op   = OP_MUL;
				c.xsel = XS_X;
				c.ysel = YS_B;
				c.msel = MS_N;
				c.dst  = DS_X;
			end
			S_SQB: begin
				c.op   = OP_MUL;
				c.xsel = XS_B;
				c.ysel = YS_B;
				c.msel = MS_N;
				c.dst  = DS_B;
			end
			S_SHD: begin
				c.op     = OP_SHD;
				c.target = S_ETOP;
			end
			S_TEST: begin
				c.op     = OP_TEST;
				c.target = S_PASS;
			end
			S_RDEC: begin
				c.op     = OP_RDEC;
				c.target = S_FAIL;
			end
			S_SQX: begin
				c.op   = OP_MUL;
				c.xsel = XS_X;
				c.ysel = YS_X;
				c.msel = MS_N;
				c.dst  = DS_X;
			end
			S_CHK: begin
				c.op     = OP_CHK;
				c.target = S_RDEC;
			end
			S_PASS: begin
				c.op      = OP_EMIT;
				c.verdict = 1'b1;
			end
			S_FAIL: begin
				c.op      = OP_EMIT;
				c.verdict = 1'b0;
			end
			default: begin
				c.op     = OP_JMP;
				c.target = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hdl/miller_rabin_witness_test.sv
// ----------------------------------------------------------------------------
// Miller-Rabin witness test
// One Miller-Rabin round per item: reduce the witness modulo n-1, raise it to
// the odd part d of n-1 modulo n, then square up to r-1 more times.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over candidate and witness_raw; the
// item is taken on that edge and busy rises on the next cycle. The verdict
// appears on probable_prime with done high for exactly one cycle, in the
// cycle that busy drops again; probable_prime keeps it until the next verdict
// but done is not held, so capture it then. One item is worked at a time.
// All arithmetic runs through a single shift-and-add modular multiplier, so
// an item costs 1 + bits(d) + ones(d) + s multiplies plus sequencer steps
// for every bit of d and every squaring, where s is the number of extra
// squarings made (at most r-1). That is at most 64 multiplies for any 32-bit
// candidate, fewer when the round ends early, and none when the candidate is
// below two.
// ----------------------------------------------------------------------------
`default_nettype none

module miller_rabin_witness_test
	import mrwt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] candidate,
	input  wire logic [31:0] witness_raw,
	output logic             done,
	output logic             probable_prime
);

	// Control state
	step_t            step_q, step_d;
	logic             run_q, run_d;
	logic             phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             done_q, done_d;
	logic             pp_q, pp_d;

	// Datapath registers
	word_t          n_q, nm1_q, w_q, x_q, b_q, d_q, p_q, my_q;
	logic [R_W-1:0] r_q;

	ctrl_t ctl;
	logic  accept;
	word_t mod_val, mx, yv, mm_res;
	logic [WIDTH:0] dbl, dbl_red, sum, sum_red;

	// Datapath strobes
	logic ld_in, mm_start, mm_dbl, mm_add, mm_last, d_shift, r_inc, r_dec;

	assign ctl            = ctrl_rom(step_q);
	assign busy           = (step_q != S_IDLE);
	assign accept         = start && !busy;
	assign done           = done_q;
	assign probable_prime = pp_q;

	// Select multiplier operands
	always_comb begin
		mod_val = (ctl.msel == MS_NM1) ? nm1_q : n_q;
		case (ctl.xsel)
			XS_X:    mx = x_q;
			XS_B:    mx = b_q;
			default: mx = word_t'(1);
		endcase
		case (ctl.ysel)
			YS_B:    yv = b_q;
			YS_X:    yv = x_q;
			default: yv = w_q;
		endcase
	end

	// Double or add, then reduce once
	always_comb begin
		dbl     = {p_q, 1'b0};
		dbl_red = (dbl >= {1'b0, mod_val}) ? dbl - {1'b0, mod_val} : dbl;
		sum     = {1'b0, p_q} + {1'b0, (my_q[WIDTH-1] ? mx : word_t'(0))};
		sum_red = (sum >= {1'b0, mod_val}) ? sum - {1'b0, mod_val} : sum;
		mm_res  = sum_red[WIDTH-1:0];
	end

	// Decode the current control word
	always_comb begin
		step_d   = step_q;
		run_d    = run_q;
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		done_d   = 1'b0;
		pp_d     = pp_q;
		ld_in    = 1'b0;
		mm_start = 1'b0;
		mm_dbl   = 1'b0;
		mm_add   = 1'b0;
		mm_last  = 1'b0;
		d_shift  = 1'b0;
		r_inc    = 1'b0;
		r_dec    = 1'b0;
		unique case (ctl.op)
			OP_WAIT: begin
				if (accept) begin
					ld_in  = 1'b1;
					step_d = step_q + step_t'(1);
				end
			end
			OP_JLT2: begin
				step_d = (n_q < word_t'(2)) ? ctl.target : step_q + step_t'(1);
			end
			OP_MUL: begin
				if (!run_q) begin
					mm_start = 1'b1;
					run_d    = 1'b1;
					phase_d  = 1'b0;
					cnt_d    = CNT_W'(WIDTH);
				end else if (!phase_q) begin
					mm_dbl  = 1'b1;
					phase_d = 1'b1;
				end else begin
					mm_add  = 1'b1;
					phase_d = 1'b0;
					cnt_d   = cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						mm_last = 1'b1;
						run_d   = 1'b0;
						step_d  = step_q + step_t'(1);
					end
				end
			end
			OP_NORM: begin
				if (!d_q[0]) begin
					d_shift = 1'b1;
					r_inc   = 1'b1;
				end else begin
					step_d = step_q + step_t'(1);
				end
			end
			OP_JDZ: begin
				step_d = (d_q == '0) ? ctl.target : step_q + step_t'(1);
			end
			OP_JBIT0: begin
				step_d = (!d_q[0]) ? ctl.target : step_q + step_t'(1);
			end
			OP_SHD: begin
				d_shift = 1'b1;
				step_d  = ctl.target;
			end
			OP_TEST: begin
				if (x_q == word_t'(1) || x_q == nm1_q) step_d = ctl.target;
				else step_d = step_q + step_t'(1);
			end
			OP_RDEC: begin
				if (r_q <= R_W'(1)) begin
					step_d = ctl.target;
				end else begin
					r_dec  = 1'b1;
					step_d = step_q + step_t'(1);
				end
			end
			OP_CHK: begin
				if (x_q == word_t'(1)) step_d = S_FAIL;
				else if (x_q == nm1_q) step_d = S_PASS;
				else step_d = ctl.target;
			end
			OP_EMIT: begin
				done_d = 1'b1;
				pp_d   = ctl.verdict;
				step_d = S_IDLE;
			end
			OP_JMP: step_d = ctl.target;
			default: step_d = S_IDLE;
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= S_IDLE;
			run_q   <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			pp_q    <= 1'b0;
		end else begin
			step_q  <= step_d;
			run_q   <= run_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
			pp_q    <= pp_d;
		end
	end

	// Load the item and hold the working values
	always_ff @(posedge clk) begin
		if (ld_in) begin
			n_q   <= candidate[WIDTH-1:0];
			nm1_q <= candidate[WIDTH-1:0] - word_t'(1);
			d_q   <= candidate[WIDTH-1:0] - word_t'(1);
			w_q   <= witness_raw[WIDTH-1:0];
			x_q   <= word_t'(1);
			r_q   <= '0;
		end else begin
			if (d_shift) d_q <= d_q >> 1;
			if (r_inc)   r_q <= r_q + R_W'(1);
			if (r_dec)   r_q <= r_q - R_W'(1);
			if (mm_last && ctl.dst == DS_X) x_q <= mm_res;
			if (mm_last && ctl.dst == DS_B) b_q <= mm_res;
		end
	end

	// Multiplier partial product, multiplier bits MSB first
	always_ff @(posedge clk) begin
		if (mm_start) begin
			p_q  <= '0;
			my_q <= yv;
		end else if (mm_dbl) begin
			p_q <= dbl_red[WIDTH-1:0];
		end else if (mm_add) begin
			p_q  <= mm_res;
			my_q <= my_q << 1;
		end
	end

endmodule

`default_nettype wire

>>> hdl/mrwt_checker.sv
// ----------------------------------------------------------------------------
// Miller-Rabin witness test port checker
// Watches the command handshake and the result strobe on the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrwt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	// An accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted but busy did not rise");

	// A result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// The result shows as the block returns to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("done outside the end of an item");

	// Every item ends with a result
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("item finished without a result");

endmodule

bind miller_rabin_witness_test mrwt_checker u_mrwt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire

>>> sim/tb_miller_rabin_witness_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin witness test bench
// Feeds candidate/witness items through the start/busy handshake, works out
// the verdict of each accepted item with a cycle-free software round, and
// checks every done strobe against the oldest outstanding verdict. A directed
// set covers the corner candidates and witnesses; random items follow, most
// of them odd candidates, primes and numbers with long runs of squarings.
// ----------------------------------------------------------------------------

module tb_miller_rabin_witness_test;
	import mrwt_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 5_000_000;
	localparam int unsigned SETTLE_CYCLES = 7000;
	localparam int          RANDOM_ITEMS  = 76;
	localparam int          CALM_ITEMS    = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	word_t       candidate = '0;
	word_t       witness_raw = '0;
	logic        busy;
	logic        done;
	logic        probable_prime;
	int unsigned cycle_count = 0;

	typedef struct {
		word_t cand;
		word_t wit;
		logic  verdict;
	} round_rec_t;

	// Outstanding verdicts, oldest first, and the software round behind them
	class verdict_ledger;
		round_rec_t  awaited[$];
		int unsigned fails = 0;

		function logic mr_round_verdict(word_t n32, word_t w32);
			bit [63:0] n, nm1, a, d, x, base, e;
			int unsigned r;
			int unsigned i;
			n = n32;
			if (n < 2)
				return 1'b0;
			nm1 = n - 1;
			a = w32 % nm1;
			d = nm1;
			r = 0;
			// split n-1 into d * 2^r with d odd
			while (d[0] == 1'b0) begin
				d = d >> 1;
				r++;
			end
			// x = a^d mod n, right to left
			x = 1;
			base = a % n;
			e = d;
			while (e != 0) begin
				if (e[0])
					x = (x * base) % n;
				base = (base * base) % n;
				e = e >> 1;
			end
			if (x == 1 || x == nm1)
				return 1'b1;
			// square up to r-1 more times
			for (i = 1; i < r; i++) begin
				x = (x * x) % n;
				if (x == 1)
					return 1'b0;
				if (x == nm1)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_item(word_t c, word_t w);
			round_rec_t rec;
			rec.cand = c;
			rec.wit = w;
			rec.verdict = mr_round_verdict(c, w);
			awaited = {awaited, rec};
		endfunction

		function void check_verdict(logic got);
			round_rec_t rec;
			if (awaited.size() == 0) begin
				$error("probable_prime: no item outstanding, expected none, actual %0b", got);
				fails++;
			end else begin
				rec = awaited.pop_front();
				if (got !== rec.verdict) begin
					$error("probable_prime: expected %0b, actual %0b (candidate %0d, witness_raw %0d)",
						rec.verdict, got, rec.cand, rec.wit);
					fails++;
				end
			end
		endfunction
	endclass

	verdict_ledger ledger = new;

	miller_rabin_witness_test dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.candidate      (candidate),
		.witness_raw    (witness_raw),
		.done           (done),
		.probable_prime (probable_prime)
	);

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Count cycles and give up at the limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Take each verdict on its strobe
	always @(posedge clk) begin
		if (arst_n && done)
			ledger.check_verdict(probable_prime);
	end

	// Present one item, optionally after an idle burst, and hold it until taken
	task automatic present_item(input word_t c, input word_t w, input bit idle_ok);
		int unsigned mode;
		mode = idle_ok ? $urandom_range(0, 3) : 0;
		if (mode >= 2) begin
			start <= 1'b0;
			candidate <= $urandom;
			witness_raw <= $urandom;
			// idle across the end of the current round
			if (mode == 3) begin
				@(posedge clk);
				while (busy) @(posedge clk);
			end
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		start <= 1'b1;
		candidate <= c;
		witness_raw <= w;
		do @(posedge clk); while (busy !== 1'b0);
		ledger.note_item(c, w);
	endtask

	initial begin
		word_t       c, w;
		int unsigned pick;
		int unsigned r;
		int          i;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: candidates below two, two, even ones, trivial witnesses
		present_item(32'd0, 32'd0, 1'b1);
		present_item(32'd1, 32'hFFFF_FFFF, 1'b1);
		present_item(32'd2, 32'd12345, 1'b1);
		present_item(32'd3, 32'd0, 1'b1);
		present_item(32'd3, 32'd1, 1'b1);
		present_item(32'd7, 32'd5, 1'b1);
		present_item(32'd10, 32'd3, 1'b1);
		present_item(32'hFFFF_FFFE, 32'hAAAA_AAAA, 1'b1);
		present_item(32'h8000_0000, 32'h8000_0000, 1'b1);
		// witness reducing to zero and to one
		present_item(32'd65537, 32'd65536, 1'b1);
		present_item(32'd65537, 32'd65537, 1'b1);
		// Carmichael number and strong pseudoprimes
		present_item(32'd561, 32'd2, 1'b1);
		present_item(32'd2047, 32'd2, 1'b1);
		present_item(32'd2047, 32'd3, 1'b1);
		present_item(32'd3215031751, 32'd2, 1'b1);
		// full width and long squaring chains
		present_item(32'd4294967291, 32'hFFFF_FFFF, 1'b1);
		present_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		present_item(32'hFFFF_FFFF, 32'd2, 1'b1);
		present_item(32'h8000_0001, 32'd3, 1'b1);
		present_item(32'd3221225473, 32'd7, 1'b1);
		present_item(32'd998244353, 32'd3, 1'b1);
		present_item(32'd2147483647, 32'h7FFF_FFFD, 1'b1);
		present_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
		present_item(32'hAAAA_AAAB, 32'h5555_5555, 1'b1);

		// Random: mostly odd and prime candidates, some noise; no idling at the end
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				c = $urandom | 32'd1;
			end else if (pick < 60) begin
				case ($urandom_range(0, 9))
					0: c = 32'd3;
					1: c = 32'd97;
					2: c = 32'd257;
					3: c = 32'd65537;
					4: c = 32'd998244353;
					5: c = 32'd1000000007;
					6: c = 32'd2147483647;
					7: c = 32'd3221225473;
					8: c = 32'd4294967279;
					default: c = 32'd4294967291;
				endcase
			end else if (pick < 75) begin
				c = $urandom_range(3, 2001) | 32'd1;
			end else if (pick < 85) begin
				// k * 2^r + 1 with a large r
				r = $urandom_range(8, 30);
				c = (($urandom >> r) << r) | 32'd1;
			end else begin
				c = $urandom_range(0, 1) ? word_t'($urandom) : word_t'($urandom_range(0, 8));
			end
			case ($urandom_range(0, 9))
				0: w = 32'd0;
				1: w = c;
				2: w = c - 32'd1;
				3: w = c - 32'd2;
				4: w = 32'hFFFF_FFFF;
				default: w = $urandom;
			endcase
			present_item(c, w, i < RANDOM_ITEMS - CALM_ITEMS);
		end
		start <= 1'b0;

		// Drain, then watch for stray strobes
		while (ledger.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (ledger.fails == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
hdl/mrwt_pkg.sv
hdl/miller_rabin_witness_test.sv
hdl/mrwt_checker.sv
sim/tb_miller_rabin_witness_test.sv
